[rtl/fte_pkg.sv]
// ----------------------------------------------------------------------------
// fte_pkg
// Shared widths, path kind codes and the topology size table for the
// fat-tree path enumerator.
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int KW    = 4;   // half radix register width
  localparam int IDXW  = 10;  // host / request index width
  localparam int SWW   = 7;   // edge / aggregation switch index width
  localparam int COREW = 6;   // core switch index width
  localparam int LIMW  = 11;  // index bound width, holds 1024

  localparam logic [1:0] PATH_SAME_EDGE = 2'd0;
  localparam logic [1:0] PATH_SAME_POD  = 2'd1;
  localparam logic [1:0] PATH_CORE      = 2'd2;

  // Number of hosts (2k^3) or edge switches (2k^2) for a clamped k.
  function automatic logic [LIMW-1:0] index_bound(input logic edge_mode,
                                                  input logic [KW-1:0] k);
    logic [LIMW-1:0] hosts;
    logic [LIMW-1:0] edges;
    case (k)
      4'd1:    begin hosts = 11'd2;    edges = 11'd2;   end
      4'd2:    begin hosts = 11'd16;   edges = 11'd8;   end
      4'd3:    begin hosts = 11'd54;   edges = 11'd18;  end
      4'd4:    begin hosts = 11'd128;  edges = 11'd32;  end
      4'd5:    begin hosts = 11'd250;  edges = 11'd50;  end
      4'd6:    begin hosts = 11'd432;  edges = 11'd72;  end
      4'd7:    begin hosts = 11'd686;  edges = 11'd98;  end
      default: begin hosts = 11'd1024; edges = 11'd128; end
    endcase
    return edge_mode ? edges : hosts;
  endfunction

endpackage

[rtl/fte_div.sv]
// ----------------------------------------------------------------------------
// fte_div
// Restoring divider, one quotient bit per cycle. Divides an index by the
// half radix; shared by every division of a request.
// ----------------------------------------------------------------------------
module fte_div import fte_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IDXW-1:0] dividend,
  input  logic [KW-1:0]   divisor,
  output logic            done,
  output logic [IDXW-1:0] quotient,
  output logic [KW-1:0]   remainder
);

  localparam int CNTW = $clog2(IDXW + 1);

  logic [IDXW-1:0] dvd;
  logic [KW-1:0]   rem;
  logic [KW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic [KW:0]     trial;
  logic [KW+1:0]   diff;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem, dvd[IDXW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNTW'(IDXW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNTW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // quotient bits shift into the dividend register as it empties
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      if (!diff[KW+1]) begin
        rem <= diff[KW-1:0];
        dvd <= {dvd[IDXW-2:0], 1'b1};
      end else begin
        rem <= trial[KW-1:0];
        dvd <= {dvd[IDXW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

[rtl/fat_tree_path_enumerator.sv]
// ----------------------------------------------------------------------------
// fat_tree_path_enumerator
// Enumerates every equal-cost path between a pair of hosts or a pair of edge switches
// of a fat tree with half radix k.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. Host requests run four
// divisions by k (host to edge switch, edge switch to pod) and edge switch
// requests run two, on the one shared bit-serial divider; then one path is
// emitted per cycle while out_ready is high: 1 for the same edge switch, k
// within a pod, k*k across pods. An index out of range skips the divisions
// and gives one result with valid_res low.
module fat_tree_path_enumerator import fte_pkg::*; #(
  parameter int MAX_HALF_RADIX = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [KW-1:0]    cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [IDXW-1:0]  src_index,
  input  logic [IDXW-1:0]  dst_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             valid_res,
  output logic [1:0]       path_kind,
  output logic [SWW-1:0]   src_edge,
  output logic [SWW-1:0]   src_agg,
  output logic [COREW-1:0] core_switch,
  output logic [SWW-1:0]   dst_agg,
  output logic [SWW-1:0]   dst_edge,
  output logic [IDXW-1:0]  dst_host,
  output logic             last
);

  localparam int AW = (MAX_HALF_RADIX > 1) ? $clog2(MAX_HALF_RADIX) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV_SRC = 3'd1;
  localparam logic [2:0] S_DIV_DST = 3'd2;
  localparam logic [2:0] S_DIV_SP  = 3'd3;
  localparam logic [2:0] S_DIV_DP  = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;

  logic [2:0]      state, state_next;
  logic [KW-1:0]   half_radix;
  logic [KW-1:0]   k;
  logic            bad;
  logic            mode;
  logic [IDXW-1:0] src, dst;
  logic [SWW-1:0]  se, de, spk, dpk;
  logic [AW-1:0]   agg, core;
  logic [COREW-1:0] core_idx;
  logic            accept, load;
  logic            in_bad;
  logic            div_start, div_done;
  logic [IDXW-1:0] div_dividend, div_quot;
  logic [KW-1:0]   div_rem;
  logic [1:0]      kind;
  logic            agg_end, core_end, path_end;

  // configuration register and clamped half radix
  always_ff @(posedge clk) begin
    if (rst) begin
      half_radix <= KW'(2);
    end else if (cfg_we) begin
      half_radix <= cfg_wdata;
    end
  end

  always_comb begin
    if (half_radix == '0) begin
      k = KW'(1);
    end else if (half_radix > KW'(MAX_HALF_RADIX)) begin
      k = KW'(MAX_HALF_RADIX);
    end else begin
      k = half_radix;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = !out_valid || out_ready;
  assign in_bad   = ({1'b0, src_index} >= index_bound(action, k)) ||
                    ({1'b0, dst_index} >= index_bound(action, k));

  // shared divider
  fte_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (k),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // path classification and end-of-run flags
  always_comb begin
    if (se == de) begin
      kind = PATH_SAME_EDGE;
    end else if (spk == dpk) begin
      kind = PATH_SAME_POD;
    end else begin
      kind = PATH_CORE;
    end
  end

  assign agg_end  = (KW'(agg) + KW'(1)) == k;
  assign core_end = (KW'(core) + KW'(1)) == k;
  always_comb begin
    if (bad || kind == PATH_SAME_EDGE) begin
      path_end = 1'b1;
    end else if (kind == PATH_SAME_POD) begin
      path_end = agg_end;
    end else begin
      path_end = agg_end && core_end;
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = src;
    unique case (state)
      S_IDLE: begin
        div_dividend = action ? {{(IDXW-SWW){1'b0}}, src_index[SWW-1:0]} : src_index;
        if (accept) begin
          if (in_bad) begin
            state_next = S_EMIT;
          end else begin
            div_start  = 1'b1;
            state_next = action ? S_DIV_SP : S_DIV_SRC;
          end
        end
      end
      S_DIV_SRC: begin
        div_dividend = dst;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_DIV_DST;
        end
      end
      S_DIV_DST: begin
        div_dividend = {{(IDXW-SWW){1'b0}}, se};
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_DIV_SP;
        end
      end
      S_DIV_SP: begin
        div_dividend = {{(IDXW-SWW){1'b0}}, de};
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_DIV_DP;
        end
      end
      S_DIV_DP: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load && path_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request registers and division results
  always_ff @(posedge clk) begin
    if (accept) begin
      mode     <= action;
      src      <= src_index;
      dst      <= dst_index;
      bad      <= in_bad;
      se       <= src_index[SWW-1:0];
      de       <= dst_index[SWW-1:0];
      agg      <= '0;
      core     <= '0;
      core_idx <= '0;
    end else begin
      unique case (state)
        S_DIV_SRC: if (div_done) se <= div_quot[SWW-1:0];
        S_DIV_DST: if (div_done) de <= div_quot[SWW-1:0];
        S_DIV_SP:  if (div_done) spk <= se - SWW'(div_rem);
        S_DIV_DP:  if (div_done) dpk <= de - SWW'(div_rem);
        S_EMIT: begin
          if (load) begin
            core_idx <= core_idx + 1'b1;
            if (kind == PATH_CORE && !core_end) begin
              core <= core + 1'b1;
            end else begin
              core <= '0;
              agg  <= agg + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && load) begin
      last        <= path_end;
      valid_res   <= !bad;
      path_kind   <= '0;
      src_edge    <= '0;
      src_agg     <= '0;
      core_switch <= '0;
      dst_agg     <= '0;
      dst_edge    <= '0;
      dst_host    <= '0;
      if (!bad) begin
        path_kind <= kind;
        dst_edge  <= de;
        dst_host  <= mode ? '0 : dst;
        if (kind != PATH_SAME_EDGE) begin
          src_edge <= se;
          src_agg  <= spk + SWW'(agg);
        end
        if (kind == PATH_CORE) begin
          core_switch <= core_idx;
          dst_agg     <= dpk + SWW'(agg);
        end
      end
    end
  end

endmodule

[test/fat_tree_path_enumerator_tb.sv]
// ----------------------------------------------------------------------------
// fat_tree_path_enumerator_tb
// Drives host and edge switch route requests into the fat-tree path
// enumerator over a range of half radix settings and checks every emitted
// path, field by field and in order, against a local path predictor.
// ----------------------------------------------------------------------------
module fat_tree_path_enumerator_tb import fte_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int SETTLE       = 8;
  localparam int TAIL_CYCLES  = 20;
  localparam int RAND_PER_SET = 36;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic            action;
    logic [IDXW-1:0] src;
    logic [IDXW-1:0] dst;
  } route_req_t;

  typedef struct {
    logic             valid_res;
    logic [1:0]       kind;
    logic [SWW-1:0]   src_edge;
    logic [SWW-1:0]   src_agg;
    logic [COREW-1:0] core;
    logic [SWW-1:0]   dst_agg;
    logic [SWW-1:0]   dst_edge;
    logic [IDXW-1:0]  dst_host;
    logic             last;
  } path_rec_t;

  // DUT signals
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [KW-1:0]    cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             action = 1'b0;
  logic [IDXW-1:0]  src_index = '0;
  logic [IDXW-1:0]  dst_index = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             valid_res;
  logic [1:0]       path_kind;
  logic [SWW-1:0]   src_edge;
  logic [SWW-1:0]   src_agg;
  logic [COREW-1:0] core_switch;
  logic [SWW-1:0]   dst_agg;
  logic [SWW-1:0]   dst_edge;
  logic [IDXW-1:0]  dst_host;
  logic             last;

  // Testbench state
  route_req_t  request_q[$];
  path_rec_t   route_q[$];
  logic [KW-1:0] radix_reg = 4'd2;
  bit          idle_on = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          radix_list[$] = '{8, 1, 0, 15, 4, 3, 9, 5, 6, 7, 8, 2};

  fat_tree_path_enumerator u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .src_index  (src_index),
    .dst_index  (dst_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .path_kind  (path_kind),
    .src_edge   (src_edge),
    .src_agg    (src_agg),
    .core_switch(core_switch),
    .dst_agg    (dst_agg),
    .dst_edge   (dst_edge),
    .dst_host   (dst_host),
    .last       (last)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register value as the block uses it: 0 acts as 1, above max acts as max
  function automatic int eff_radix(input logic [KW-1:0] v);
    if (v < 1) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  function automatic path_rec_t mk_path(input int vld, input logic [1:0] kind,
                                        input int se, input int sa, input int cs,
                                        input int da, input int de, input int dh,
                                        input bit lst);
    path_rec_t p;
    p.valid_res = vld[0];
    p.kind      = kind;
    p.src_edge  = se[SWW-1:0];
    p.src_agg   = sa[SWW-1:0];
    p.core      = cs[COREW-1:0];
    p.dst_agg   = da[SWW-1:0];
    p.dst_edge  = de[SWW-1:0];
    p.dst_host  = dh[IDXW-1:0];
    p.last      = lst;
    return p;
  endfunction

  // Expected path list for one request, appended to route_q
  task automatic enumerate_paths(input logic act, input logic [IDXW-1:0] s,
                                 input logic [IDXW-1:0] d);
    int kk, bound, se, de, sp, dp, dh;
    kk = eff_radix(radix_reg);
    bound = act ? 2 * kk * kk : 2 * kk * kk * kk;
    if (int'(s) >= bound || int'(d) >= bound) begin
      route_q = {route_q, mk_path(0, PATH_SAME_EDGE, 0, 0, 0, 0, 0, 0, 1'b1)};
      return;
    end
    if (act) begin
      se = int'(s);
      de = int'(d);
      dh = 0;
    end else begin
      se = int'(s) / kk;
      de = int'(d) / kk;
      dh = int'(d);
    end
    sp = se / kk;
    dp = de / kk;
    if (se == de) begin
      route_q = {route_q, mk_path(1, PATH_SAME_EDGE, 0, 0, 0, 0, de, dh, 1'b1)};
    end else if (sp == dp) begin
      for (int a = 0; a < kk; a++)
        route_q = {route_q, mk_path(1, PATH_SAME_POD, se, sp * kk + a, 0, 0, de, dh,
                                    a == kk - 1)};
    end else begin
      for (int a = 0; a < kk; a++)
        for (int c = 0; c < kk; c++)
          route_q = {route_q, mk_path(1, PATH_CORE, se, sp * kk + a, a * kk + c,
                                      dp * kk + a, de, dh,
                                      (a == kk - 1) && (c == kk - 1))};
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_req(input logic act, input int s, input int d);
    route_req_t r;
    r.action = act;
    r.src    = s[IDXW-1:0];
    r.dst    = d[IDXW-1:0];
    request_q = {request_q, r};
  endtask

  // Mostly well-formed requests across the tree, some with one index out of range,
  // some pure noise
  task automatic add_random_req(input int kk);
    int edges, bound, pick, se, de, sp, dp;
    route_req_t r;
    edges = 2 * kk * kk;
    r.action = 1'($urandom_range(0, 1));
    bound = r.action ? edges : edges * kk;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.src = IDXW'($urandom);
      r.dst = IDXW'($urandom);
    end else if (pick < 18 && bound < 1024) begin
      if ($urandom_range(0, 1)) begin
        r.src = IDXW'($urandom_range(bound, 1023));
        r.dst = IDXW'($urandom_range(0, bound - 1));
      end else begin
        r.src = IDXW'($urandom_range(0, bound - 1));
        r.dst = IDXW'($urandom_range(bound, 1023));
      end
    end else begin
      se = $urandom_range(0, edges - 1);
      sp = se / kk;
      case ($urandom_range(0, 2))
        0: de = se;
        1: de = sp * kk + $urandom_range(0, kk - 1);
        default: begin
          dp = (sp + $urandom_range(1, 2 * kk - 1)) % (2 * kk);
          de = dp * kk + $urandom_range(0, kk - 1);
        end
      endcase
      if (r.action) begin
        r.src = IDXW'(se);
        r.dst = IDXW'(de);
      end else begin
        r.src = IDXW'(se * kk + $urandom_range(0, kk - 1));
        r.dst = IDXW'(de * kk + $urandom_range(0, kk - 1));
      end
    end
    request_q = {request_q, r};
  endtask

  // Wait until every request is taken and every path has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || route_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_radix(input int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[KW-1:0];
    radix_reg = v[KW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        enumerate_paths(action, src_index, dst_index);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          route_req_t r;
          r = request_q.pop_front();
          action    <= r.action;
          src_index <= r.src;
          dst_index <= r.dst;
          in_valid  <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0)
            send_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Path monitor and ready control
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        path_rec_t want;
        if (route_q.size() == 0) begin
          report_mismatch("path item with nothing expected");
        end else begin
          want = route_q.pop_front();
          if (valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res %0d want %0d", valid_res, want.valid_res));
          if (path_kind !== want.kind)
            report_mismatch($sformatf("path_kind %0d want %0d", path_kind, want.kind));
          if (src_edge !== want.src_edge)
            report_mismatch($sformatf("src_edge %0d want %0d", src_edge, want.src_edge));
          if (src_agg !== want.src_agg)
            report_mismatch($sformatf("src_agg %0d want %0d", src_agg, want.src_agg));
          if (core_switch !== want.core)
            report_mismatch($sformatf("core_switch %0d want %0d", core_switch, want.core));
          if (dst_agg !== want.dst_agg)
            report_mismatch($sformatf("dst_agg %0d want %0d", dst_agg, want.dst_agg));
          if (dst_edge !== want.dst_edge)
            report_mismatch($sformatf("dst_edge %0d want %0d", dst_edge, want.dst_edge));
          if (dst_host !== want.dst_host)
            report_mismatch($sformatf("dst_host %0d want %0d", dst_host, want.dst_host));
          if (last !== want.last)
            report_mismatch($sformatf("last %0d want %0d", last, want.last));
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0)
          stall_left <= $urandom_range(1, 15);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_on = 1'b1;

    // Directed requests at the reset half radix of 2
    add_req(1'b0, 0, 0);        // source equals destination
    add_req(1'b0, 0, 1);        // same edge switch
    add_req(1'b0, 0, 3);        // same pod
    add_req(1'b0, 0, 15);       // across pods
    add_req(1'b0, 15, 0);
    add_req(1'b0, 16, 0);       // source host out of range
    add_req(1'b0, 0, 16);       // destination host out of range
    add_req(1'b0, 1023, 1023);
    add_req(1'b0, 5, 5);
    add_req(1'b1, 0, 0);
    add_req(1'b1, 3, 3);
    add_req(1'b1, 0, 1);        // edge switches in one pod
    add_req(1'b1, 0, 7);
    add_req(1'b1, 7, 0);
    add_req(1'b1, 8, 0);        // edge index out of range
    add_req(1'b1, 0, 8);
    add_req(1'b1, 1023, 0);
    add_req(1'b1, 6, 7);
    wait_drained();

    // One phase per half radix setting
    foreach (radix_list[i]) begin
      write_radix(radix_list[i]);
      if (i == 4)
        hold_go = 1'b1;
      if (i >= radix_list.size() - 2)
        idle_on = 1'b0;
      if (i == 0) begin
        // widest tree: full index span
        add_req(1'b0, 1023, 0);
        add_req(1'b0, 0, 1023);
        add_req(1'b1, 127, 0);
        add_req(1'b1, 128, 5);
        add_req(1'b0, 7, 0);
      end
      for (int n = 0; n < RAND_PER_SET; n++)
        add_random_req(eff_radix(radix_list[i][KW-1:0]));
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (route_q.size() != 0)
      report_mismatch("expected paths never came back");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
